// ----- rtl/pwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_pkg: shared types and constants of the page walk cache
// Request codes, register indexes, queue command, result and tag row layouts.
// ----------------------------------------------------------------------------
package pwc_pkg;

  localparam int LEVELS      = 4;
  localparam int LVL_W       = 2;
  localparam int MAX_SETS    = 64;
  localparam int MAX_WAYS    = 8;
  localparam int SET_W       = 6;
  localparam int WAY_W       = 3;
  localparam int TAG_W       = 36;
  localparam int ADDR_W      = 48;
  localparam int SCNT_W      = 7;
  localparam int WCNT_W      = 4;
  localparam int ROWS        = LEVELS * MAX_SETS;
  localparam int ROW_AW      = LVL_W + SET_W;
  localparam int PAGE_SHIFT  = 12;
  localparam int LEVEL_SHIFT = 9;
  localparam int MOD_BITS    = 4;
  localparam int MOD_STEPS   = TAG_W / MOD_BITS;
  localparam int STEP_W      = 4;
  localparam int RES_W       = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;

  localparam logic [RES_W-1:0] HIT_NONE = RES_W'(LEVELS);

  // request kinds
  typedef enum logic [1:0] {
    REQ_LOOKUP   = 2'd0,
    REQ_FILL     = 2'd1,
    REQ_COMPLETE = 2'd2,
    REQ_INVAL    = 2'd3
  } req_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETS0 = 3'd0,
    CFG_SETS1 = 3'd1,
    CFG_SETS2 = 3'd2,
    CFG_SETS3 = 3'd3,
    CFG_WAYS0 = 3'd4,
    CFG_WAYS1 = 3'd5,
    CFG_WAYS2 = 3'd6,
    CFG_WAYS3 = 3'd7
  } cfg_e;

  typedef struct packed {
    logic [LEVELS-1:0][SCNT_W-1:0] sets;
    logic [LEVELS-1:0][WCNT_W-1:0] ways;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    req_e                          req;
    logic [LVL_W-1:0]              lvl;
    logic [LEVELS-1:0][TAG_W-1:0]  page;
    logic [LEVELS-1:0]             wide;
    logic [LEVELS-1:0][SET_W-1:0]  set;
  } cmd_t;

  // result, hit_level in the lowest bits
  typedef struct packed {
    logic [RES_W-1:0] levels_cleared;
    logic [WAY_W-1:0] way_written;
    logic             was_present;
    logic [RES_W-1:0] hit_level;
  } res_t;

  // one set of one level
  typedef struct packed {
    logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    logic [MAX_WAYS-1:0]            vld;
    logic [MAX_WAYS-1:0][WAY_W-1:0] rank;
  } row_t;

  function automatic logic [SCNT_W-1:0] eff_sets(logic [SCNT_W-1:0] v);
    logic [SCNT_W-1:0] r;
    r = v;
    if (v == '0) r = SCNT_W'(1);
    else if (v > SCNT_W'(MAX_SETS)) r = SCNT_W'(MAX_SETS);
    return r;
  endfunction

  function automatic logic [WCNT_W-1:0] eff_ways(logic [WCNT_W-1:0] v);
    logic [WCNT_W-1:0] r;
    r = v;
    if (v == '0) r = WCNT_W'(1);
    else if (v > WCNT_W'(MAX_WAYS)) r = WCNT_W'(MAX_WAYS);
    return r;
  endfunction

  function automatic row_t reset_row();
    row_t r;
    r.tag = '1;
    r.vld = '0;
    for (int w = 0; w < MAX_WAYS; w++) r.rank[w] = WAY_W'(w);
    return r;
  endfunction

endpackage

// ----- rtl/pwc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_front: request intake and set computation
// Takes a request, forms the page number of every level and reduces each
// modulo its set count, four bits a cycle, then hands the command on.
// ----------------------------------------------------------------------------
module pwc_front import pwc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        in_req_i,
  input  logic [ADDR_W-1:0] in_addr_i,
  input  logic [LVL_W-1:0]  in_lvl_i,
  input  cfg_t              cfg_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output cmd_t              cmd_o
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MOD  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e                       state_q, state_d;
  logic [STEP_W-1:0]             cnt_q;
  req_e                          req_q;
  logic [LVL_W-1:0]              lvl_q;
  logic [LEVELS-1:0][TAG_W-1:0]  page_q, page_d;
  logic [LEVELS-1:0]             wide_q, wide_d;
  logic [LEVELS-1:0][TAG_W-1:0]  sh_q;
  logic [LEVELS-1:0][SCNT_W-1:0] rem_q, rem_d;

  // page numbers of all levels for the incoming request
  always_comb begin
    logic [ADDR_W-1:0] pg;
    for (int k = 0; k < LEVELS; k++) begin
      if (req_e'(in_req_i) == REQ_INVAL) pg = in_addr_i >> (LEVEL_SHIFT * k);
      else pg = in_addr_i >> (PAGE_SHIFT + LEVEL_SHIFT * k);
      page_d[k] = pg[TAG_W-1:0];
      wide_d[k] = |pg[ADDR_W-1:TAG_W];
    end
  end

  // four restoring remainder steps per level, msb first
  always_comb begin
    logic [SCNT_W-1:0] r;
    logic [SCNT_W-1:0] s;
    logic [SCNT_W:0]   t;
    for (int k = 0; k < LEVELS; k++) begin
      r = rem_q[k];
      s = eff_sets(cfg_i.sets[k]);
      for (int j = 0; j < MOD_BITS; j++) begin
        t = {r, sh_q[k][TAG_W-1-j]};
        if (t >= {1'b0, s}) t = t - {1'b0, s};
        r = t[SCNT_W-1:0];
      end
      rem_d[k] = r;
    end
  end

  // sequencing
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: if (in_valid_i) state_d = F_MOD;
      F_MOD:  if (cnt_q == STEP_W'(MOD_STEPS - 1)) state_d = F_PUSH;
      F_PUSH: if (cmd_ready_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == F_MOD) cnt_q <= cnt_q + STEP_W'(1);
      else cnt_q <= '0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (state_q == F_IDLE && in_valid_i) begin
      req_q  <= req_e'(in_req_i);
      lvl_q  <= in_lvl_i;
      page_q <= page_d;
      wide_q <= wide_d;
      sh_q   <= page_d;
      rem_q  <= '0;
    end else if (state_q == F_MOD) begin
      rem_q <= rem_d;
      for (int k = 0; k < LEVELS; k++) sh_q[k] <= sh_q[k] << MOD_BITS;
    end
  end

  assign in_ready_o  = (state_q == F_IDLE);
  assign cmd_valid_o = (state_q == F_PUSH);

  always_comb begin
    cmd_o.req  = req_q;
    cmd_o.lvl  = lvl_q;
    cmd_o.page = page_q;
    cmd_o.wide = wide_q;
    for (int k = 0; k < LEVELS; k++) cmd_o.set[k] = rem_q[k][SET_W-1:0];
  end

endmodule

// ----- rtl/pwc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_queue: two-entry command queue
// Decouples request classification from the tag store sequencer.
// ----------------------------------------------------------------------------
module pwc_queue import pwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  cmd_t       ent_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = ent_q[rptr_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop) rptr_q <= ~rptr_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= push_data_i;
  end

endmodule

// ----- rtl/pwc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwc_back: tag store and request sequencer
// Reads one set row per level, evaluates hits, victims and lru ranks, writes
// the row back and registers the result for the output channel.
// ----------------------------------------------------------------------------
module pwc_back import pwc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_READ = 4'b0010,
    B_EVAL = 4'b0100,
    B_DONE = 4'b1000
  } bstate_e;

  bstate_e          state_q;
  cmd_t             cmd_q;
  logic [LVL_W-1:0] lv_q;
  res_t             res_q, res_d;
  logic             out_valid_q;
  res_t             out_q;

  row_t             mem_q [ROWS];
  row_t             rd_q;
  logic             rdv_q;
  logic [ROWS-1:0]  rowv_q;

  logic [ROW_AW-1:0] row_addr;
  row_t              row, wrow;
  logic              wen, fin;

  assign row_addr = {lv_q, cmd_q.set[lv_q]};

  // evaluation of the row read for the current level
  always_comb begin
    logic [WCNT_W-1:0] n;
    logic [WCNT_W-1:0] last;
    logic [TAG_W-1:0]  pg;
    logic              hit;
    logic [WAY_W-1:0]  hw, vw, place;
    logic              prom;
    n     = eff_ways(cfg_i.ways[lv_q]);
    last  = n - WCNT_W'(1);
    pg    = cmd_q.page[lv_q];
    row   = rdv_q ? rd_q : reset_row();
    hit   = 1'b0;
    hw    = '0;
    vw    = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (WCNT_W'(w) < n && row.vld[w] && row.tag[w] == pg && !cmd_q.wide[lv_q]) begin
        hit = 1'b1;
        hw  = WAY_W'(w);
      end
      if (WCNT_W'(w) < n && row.rank[w] == last[WAY_W-1:0]) vw = WAY_W'(w);
    end
    wrow  = row;
    wen   = 1'b0;
    fin   = 1'b0;
    prom  = 1'b0;
    place = row.rank[hw];
    res_d = res_q;
    case (cmd_q.req)
      REQ_LOOKUP: begin
        if (hit) begin
          res_d.hit_level = RES_W'(lv_q);
          fin = 1'b1;
          if (lv_q == '0) begin
            prom = 1'b1;
            wen  = 1'b1;
          end
        end else if (lv_q == LVL_W'(LEVELS - 1)) begin
          res_d.hit_level = HIT_NONE;
          fin = 1'b1;
        end
      end
      REQ_FILL: begin
        wrow.tag[vw]      = pg;
        wrow.vld[vw]      = 1'b1;
        res_d.way_written = vw;
        wen = 1'b1;
        fin = 1'b1;
      end
      REQ_COMPLETE: begin
        if (hit) begin
          res_d.was_present = 1'b1;
        end else begin
          wrow.tag[vw]      = pg;
          wrow.vld[vw]      = 1'b1;
          res_d.way_written = vw;
          place             = row.rank[vw];
        end
        prom = 1'b1;
        wen  = 1'b1;
        fin  = 1'b1;
      end
      REQ_INVAL: begin
        if (hit) begin
          wrow.vld[hw] = 1'b0;
          res_d.levels_cleared = res_q.levels_cleared + RES_W'(1);
          wen = 1'b1;
        end
        fin = (lv_q == LVL_W'(LEVELS - 1));
      end
      default: fin = 1'b1;
    endcase
    // lru promotion: chosen rank goes to zero, younger ranks age
    if (prom) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (WCNT_W'(w) < n) begin
          if (row.rank[w] == place) wrow.rank[w] = '0;
          else if (row.rank[w] < place) wrow.rank[w] = row.rank[w] + WAY_W'(1);
        end
      end
    end
  end

  // tag store memory
  always_ff @(posedge clk_i) begin
    if (state_q == B_EVAL && wen) mem_q[row_addr] <= wrow;
    if (state_q == B_READ) rd_q <= mem_q[row_addr];
  end

  // control, row valid bits and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      rowv_q      <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      lv_q        <= '0;
    end else begin
      // output valid: set on completion, cleared when taken
      if (state_q == B_DONE && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        B_IDLE: begin
          if (cmd_valid_i) begin
            lv_q    <= (cmd_i.req == REQ_FILL) ? cmd_i.lvl : '0;
            state_q <= B_READ;
          end
        end
        B_READ: begin
          rdv_q   <= rowv_q[row_addr];
          state_q <= B_EVAL;
        end
        B_EVAL: begin
          if (wen) rowv_q[row_addr] <= 1'b1;
          if (fin) begin
            state_q <= B_DONE;
          end else begin
            lv_q    <= lv_q + LVL_W'(1);
            state_q <= B_READ;
          end
        end
        B_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
      res_q <= '0;
    end else if (state_q == B_EVAL) begin
      res_q <= res_d;
    end
    if (state_q == B_DONE && (!out_valid_q || out_ready_i)) out_q <= res_q;
  end

  assign cmd_ready_o = (state_q == B_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_EVAL |-> $past(state_q) == B_READ)
    else $error("row evaluated without a preceding read");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == B_DONE))
    else $error("result raised outside of completion");

  a_fill_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ && cmd_q.req == REQ_FILL) |-> lv_q == cmd_q.lvl)
    else $error("fill request reads the wrong level");
`endif

endmodule

// ----- rtl/page_walk_cache_lru_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_walk_cache_lru_unit: four-level set-associative page walk cache
// Lookup, fill, complete and invalidate requests over per-level tag stores
// with lru rank counters; one result per request.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on s_axis (tuser = kind, tdata = address and fill level),
//   one result per request leaves on m_axis. Set counts and associativity
//   are written on the cfg port while no request is in flight.
//   The front stage takes a request, reduces the page numbers of all four
//   levels modulo their set counts (four bits a cycle), then queues it. The
//   back stage probes one level at a time (row read, evaluate and write
//   back) and then hands the result off: fill and complete touch one level,
//   lookup 1 to 4 levels, invalidate always 4 levels. The front stage can
//   take a new request once it has queued the last, while the back stage
//   still works on earlier ones.
//   A result waits in the output register while the back stage already
//   starts on the next queued request; a stalled receiver only holds the
//   back stage once it has a second result ready.
//   Reset clears all row valid flags at once, so every set reads as empty
//   with ranks equal to the way index; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_walk_cache_lru_unit import pwc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,  // addr_or_page[47:0], fill_level[49:48]
  input  logic [1:0]            s_axis_tuser,  // req_type[1:0]
  // result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,  // hit_level[2:0], was_present[3],
                                               // way_written[6:4], levels_cleared[9:7]
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_ready, q_valid, q_ready;
  cmd_t cmd, q_cmd;
  res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LEVELS; k++) begin
        cfg_q.sets[k] <= SCNT_W'(1);
        cfg_q.ways[k] <= WCNT_W'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_SETS0: cfg_q.sets[0] <= cfg_data_i;
        CFG_SETS1: cfg_q.sets[1] <= cfg_data_i;
        CFG_SETS2: cfg_q.sets[2] <= cfg_data_i;
        CFG_SETS3: cfg_q.sets[3] <= cfg_data_i;
        CFG_WAYS0: cfg_q.ways[0] <= cfg_data_i[WCNT_W-1:0];
        CFG_WAYS1: cfg_q.ways[1] <= cfg_data_i[WCNT_W-1:0];
        CFG_WAYS2: cfg_q.ways[2] <= cfg_data_i[WCNT_W-1:0];
        CFG_WAYS3: cfg_q.ways[3] <= cfg_data_i[WCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // request classification
  pwc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_req_i    (s_axis_tuser),
    .in_addr_i   (s_axis_tdata[ADDR_W-1:0]),
    .in_lvl_i    (s_axis_tdata[ADDR_W+LVL_W-1:ADDR_W]),
    .cfg_i       (cfg_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // command queue
  pwc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (cmd_valid),
    .push_ready_o (cmd_ready),
    .push_data_i  (cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_cmd)
  );

  // tag store sequencer
  pwc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {6'b0, res};

endmodule
